>>> sv/fpv_pkg.sv
// ----------------------------------------------------------------------------
// fpv_pkg
// Shared types and constants for the first-person view update block.
// ----------------------------------------------------------------------------
package fpv_pkg;

    localparam int TRIG_W     = 19;   // Q2.16 unit components
    localparam int MB_W       = 34;   // second multiplier operand
    localparam int MP_W       = TRIG_W + MB_W;
    localparam int TH_W       = 36;   // Q30 angle accumulator
    localparam int XY_W       = 34;   // Q3.30 rotation vector
    localparam int ATAN_DEPTH = 24;

    typedef logic signed [TRIG_W-1:0] t_trig;

    localparam logic signed [TH_W-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [TH_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [TH_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [XY_W-1:0] GAIN_Q30    = 34'sd652032874;

    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_FWD   = 3'd1;
    localparam logic [2:0] OP_BACK  = 3'd2;
    localparam logic [2:0] OP_RIGHT = 3'd3;
    localparam logic [2:0] OP_LEFT  = 3'd4;

    localparam logic [2:0] CFG_MOVE_SPEED    = 3'd0;
    localparam logic [2:0] CFG_PITCH_LIMIT   = 3'd1;
    localparam logic [2:0] CFG_MAX_HEIGHT    = 3'd2;
    localparam logic [2:0] CFG_LOWER_BOUND   = 3'd3;
    localparam logic [2:0] CFG_HEIGHT_OFFSET = 3'd4;
    localparam logic [2:0] CFG_START_X       = 3'd5;
    localparam logic [2:0] CFG_START_Y       = 3'd6;
    localparam logic [2:0] CFG_START_Z       = 3'd7;

    function automatic logic signed [TH_W-1:0] atan_q30(input int idx);
        logic signed [TH_W-1:0] v;
        case (idx)
            0:       v = 36'sd843314857;
            1:       v = 36'sd497837829;
            2:       v = 36'sd263043837;
            3:       v = 36'sd133525159;
            4:       v = 36'sd67021687;
            5:       v = 36'sd33543516;
            6:       v = 36'sd16775851;
            7:       v = 36'sd8388437;
            8:       v = 36'sd4194283;
            9:       v = 36'sd2097149;
            10:      v = 36'sd1048576;
            11:      v = 36'sd524288;
            12:      v = 36'sd262144;
            13:      v = 36'sd131072;
            14:      v = 36'sd65536;
            15:      v = 36'sd32768;
            16:      v = 36'sd16384;
            17:      v = 36'sd8192;
            18:      v = 36'sd4096;
            19:      v = 36'sd2048;
            20:      v = 36'sd1024;
            21:      v = 36'sd512;
            22:      v = 36'sd256;
            23:      v = 36'sd128;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> sv/fpv_if.sv
// ----------------------------------------------------------------------------
// fpv channel interfaces
// Valid/ready channels for input items, result rows and register writes.
// ----------------------------------------------------------------------------
interface fpv_in_if #(parameter int ANGLE_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic [2:0]                   opcode;
    logic signed [ANGLE_BITS-1:0] yaw;
    logic signed [ANGLE_BITS-1:0] pitch;
    logic [15:0]                  time_step;
    modport source (output valid, opcode, yaw, pitch, time_step, input ready);
    modport sink (input valid, opcode, yaw, pitch, time_step, output ready);
endinterface

interface fpv_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         row_index;
    logic signed [31:0] elem_x;
    logic signed [31:0] elem_y;
    logic signed [31:0] elem_z;
    logic signed [31:0] elem_w;
    logic signed [14:0] pitch_out;
    logic               last_row;
    modport source (output valid, row_index, elem_x, elem_y, elem_z, elem_w,
                    pitch_out, last_row, input ready);
    modport sink (input valid, row_index, elem_x, elem_y, elem_z, elem_w,
                  pitch_out, last_row, output ready);
endinterface

interface fpv_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> sv/fpv_cordic.sv
// ----------------------------------------------------------------------------
// fpv_cordic
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, sin and cos
// rounded to Q2.16.
// ----------------------------------------------------------------------------
module fpv_cordic import fpv_pkg::*; #(
    parameter int ANG_W      = 17,
    parameter int ANG_FRAC   = 13,
    parameter int TRIG_STEPS = 14
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [ANG_W-1:0] i_angle,
    output logic                    o_done,
    output t_trig                   o_sin,
    output t_trig                   o_cos
);

    localparam int N     = (TRIG_STEPS > ATAN_DEPTH) ? ATAN_DEPTH : TRIG_STEPS;
    localparam int CW    = $clog2(N);
    localparam int SHIFT = 30 - ANG_FRAC;

    typedef enum logic [1:0] {C_IDLE, C_RUN, C_FIN} t_cstate;

    t_cstate                 r_state;
    logic signed [TH_W-1:0]  r_th, n_th, th_a, th_b, th_c;
    logic signed [XY_W-1:0]  r_x, r_y, n_x, n_y, xs, ys, fx, fy;
    logic [CW-1:0]           r_i;
    logic                    r_neg, neg_c;

    function automatic t_trig rnd14(input logic signed [XY_W-1:0] v);
        logic signed [XY_W-1:0] t;
        t = v + XY_W'(8192);
        return t[14 +: TRIG_W];
    endfunction

    always_comb begin
        th_a = TH_W'(i_angle) <<< SHIFT;
        if (th_a > PI_Q30) begin
            th_b = th_a - TWO_PI_Q30;
        end else if (th_a < -PI_Q30) begin
            th_b = th_a + TWO_PI_Q30;
        end else begin
            th_b = th_a;
        end
        neg_c = 1'b0;
        if (th_b > HALF_PI_Q30) begin
            th_c  = th_b - PI_Q30;
            neg_c = 1'b1;
        end else if (th_b < -HALF_PI_Q30) begin
            th_c  = th_b + PI_Q30;
            neg_c = 1'b1;
        end else begin
            th_c = th_b;
        end
    end

    always_comb begin
        xs = r_x >>> r_i;
        ys = r_y >>> r_i;
        if (!r_th[TH_W-1]) begin
            n_x  = r_x - ys;
            n_y  = r_y + xs;
            n_th = r_th - atan_q30(int'(r_i));
        end else begin
            n_x  = r_x + ys;
            n_y  = r_y - xs;
            n_th = r_th + atan_q30(int'(r_i));
        end
        fx = r_neg ? -r_x : r_x;
        fy = r_neg ? -r_y : r_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_th    <= th_c;
                        r_neg   <= neg_c;
                        r_x     <= GAIN_Q30;
                        r_y     <= '0;
                        r_i     <= '0;
                        r_state <= C_RUN;
                    end
                end
                C_RUN: begin
                    r_x  <= n_x;
                    r_y  <= n_y;
                    r_th <= n_th;
                    r_i  <= r_i + CW'(1);
                    if (r_i == CW'(N - 1)) begin
                        r_state <= C_FIN;
                    end
                end
                C_FIN: begin
                    o_done  <= 1'b1;
                    o_cos   <= rnd14(fx);
                    o_sin   <= rnd14(fy);
                    r_state <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

endmodule

>>> sv/first_person_view_update.sv
// ----------------------------------------------------------------------------
// first_person_view_update
// Camera update: pitch clamp, CORDIC sin/cos, basis vectors, move with height
// clamp, then four look-at view matrix rows.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                       handshake
//  i_in      in   opcode, yaw, pitch, time_step                 valid/ready
//  o_res     out  row_index, elem_x..elem_w, pitch_out, last_row valid/ready
//  i_cfg     in   index, data                                   valid/ready
//
//  One item passes through two CORDIC runs (yaw, then pitch), 28 products on the
//  shared 19x34 multiplier (one product per cycle), a drain state and four result
//  rows.
//  i_in.ready and i_cfg.ready are high only when idle.
//  Reset loads the register defaults and places the camera at the origin.
//  A stalled o_res holds the current row; the sequencer waits on it.
// ----------------------------------------------------------------------------
module first_person_view_update import fpv_pkg::*; #(
    parameter int ANGLE_BITS = 16,
    parameter int POS_BITS   = 32,
    parameter int TRIG_STEPS = 14
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fpv_in_if.sink     i_in,
    fpv_out_if.source  o_res,
    fpv_cfg_if.sink    i_cfg
);

    localparam int PW    = ((ANGLE_BITS > 15) ? ANGLE_BITS : 15) + 1;
    localparam int EW    = ((POS_BITS > 34) ? POS_BITS : 34) + 2;
    localparam int ACC_W = ((POS_BITS > 32) ? POS_BITS : 32) + 6;

    localparam logic signed [EW-1:0] PMAX = {{(EW-POS_BITS+1){1'b0}}, {(POS_BITS-1){1'b1}}};
    localparam logic signed [EW-1:0] PMIN = ~PMAX;
    localparam logic signed [ACC_W-1:0] WMAX = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [ACC_W-1:0] WMIN = ~WMAX;

    typedef enum logic [2:0] {
        S_IDLE, S_TRIG_Y, S_TRIG_P, S_MUL, S_DOT, S_DRAIN, S_OUT
    } t_state;

    typedef enum logic [3:0] {
        U_STEP, U_DX, U_DZ, U_UX, U_UYA, U_UYB, U_UZ,
        U_MX, U_MY, U_MZ, U_DHI, U_DLO
    } t_use;

    t_state r_state;

    // configuration
    logic [15:0]          r_speed;
    logic [13:0]          r_plim;
    logic signed [31:0]   r_maxh, r_lowb;
    logic [30:0]          r_hoff;

    logic signed [POS_BITS-1:0] r_pos_x, r_pos_y, r_pos_z;

    // item
    logic [2:0]           r_op;
    logic signed [PW-1:0] r_yaw, r_pitch, pitch_ext, plim_ext, pitch_cl;
    logic [15:0]          r_ts;

    // trig and basis
    logic   r_cstart, r_csel, cdone;
    logic signed [PW-1:0] cangle;
    t_trig  csin, ccos;
    t_trig  r_sy, r_cy, r_sp, r_cp, r_dx, r_dz, r_ux, r_uy, r_uz, rx;
    logic [31:0]          r_step;
    logic signed [MP_W-1:0] r_tmp;

    // shared multiplier
    logic [3:0]           r_k;
    logic [1:0]           r_row;
    logic [2:0]           r_term;
    t_trig                mul_a, dcomp;
    logic signed [MB_W-1:0] mul_b;
    logic signed [MP_W-1:0] prod, r_prod, mtmp;
    t_use                 use_c, r_use;
    logic                 r_pend;
    logic [1:0]           r_use_row;
    logic [2:0]           r_use_term;

    // consume path
    logic                 moving, msign;
    logic signed [EW-1:0] dw, sgd, nx, ny, nz, hi, lo;
    logic signed [ACC_W-1:0] r_acc, ctb, acc_sum;
    logic signed [31:0]   r_w0, r_w1, r_w2;

    // output
    logic                 r_ovalid;
    logic [1:0]           r_orow;
    logic signed [31:0]   r_ex, r_ey, r_ez, r_ew;
    logic signed [14:0]   r_opitch;
    logic [1:0]           r_oidx;
    logic                 r_olast;
    logic                 load_out;

    function automatic t_trig rnd16(input logic signed [MP_W-1:0] v);
        logic signed [MP_W-1:0] t;
        t = v + MP_W'(32768);
        return t[16 +: TRIG_W];
    endfunction

    function automatic logic signed [POS_BITS-1:0] sat_pos(input logic signed [EW-1:0] v);
        logic signed [POS_BITS-1:0] r;
        if (v > PMAX) begin
            r = PMAX[POS_BITS-1:0];
        end else if (v < PMIN) begin
            r = PMIN[POS_BITS-1:0];
        end else begin
            r = v[POS_BITS-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat_w(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if (v > WMAX) begin
            r = WMAX[31:0];
        end else if (v < WMIN) begin
            r = WMIN[31:0];
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = (r_state == S_IDLE);

    assign o_res.valid     = r_ovalid;
    assign o_res.row_index = r_oidx;
    assign o_res.elem_x    = r_ex;
    assign o_res.elem_y    = r_ey;
    assign o_res.elem_z    = r_ez;
    assign o_res.elem_w    = r_ew;
    assign o_res.pitch_out = r_opitch;
    assign o_res.last_row  = r_olast;

    assign cangle = r_csel ? r_pitch : r_yaw;

    fpv_cordic #(
        .ANG_W      (PW),
        .ANG_FRAC   (ANGLE_BITS - 3),
        .TRIG_STEPS (TRIG_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cstart),
        .i_angle (cangle),
        .o_done  (cdone),
        .o_sin   (csin),
        .o_cos   (ccos)
    );

    // pitch clamp at accept
    always_comb begin
        pitch_ext = PW'(i_in.pitch);
        plim_ext  = PW'({1'b0, r_plim});
        if (pitch_ext > plim_ext) begin
            pitch_cl = plim_ext;
        end else if (pitch_ext < -plim_ext) begin
            pitch_cl = -plim_ext;
        end else begin
            pitch_cl = pitch_ext;
        end
    end

    // multiplier operand select
    always_comb begin
        rx     = -r_cy;
        moving = (r_op == OP_FWD) || (r_op == OP_BACK) ||
                 (r_op == OP_RIGHT) || (r_op == OP_LEFT);
        msign  = (r_op == OP_FWD) || (r_op == OP_RIGHT);
        mul_a  = '0;
        mul_b  = '0;
        use_c  = U_STEP;
        dcomp  = '0;
        if (r_state == S_MUL) begin
            case (r_k)
                4'd0: begin
                    mul_a = t_trig'({3'b000, r_ts});
                    mul_b = MB_W'({1'b0, r_speed});
                    use_c = U_STEP;
                end
                4'd1: begin mul_a = r_cp; mul_b = MB_W'(r_sy); use_c = U_DX; end
                4'd2: begin mul_a = r_cp; mul_b = MB_W'(r_cy); use_c = U_DZ; end
                4'd3: begin mul_a = r_sy; mul_b = MB_W'(r_sp); use_c = U_UX; end
                4'd4: begin mul_a = r_sy; mul_b = MB_W'(r_dx); use_c = U_UYA; end
                4'd5: begin mul_a = rx; mul_b = MB_W'(r_dz); use_c = U_UYB; end
                4'd6: begin mul_a = rx; mul_b = MB_W'(r_sp); use_c = U_UZ; end
                4'd7: begin
                    mul_a = (r_op == OP_FWD || r_op == OP_BACK) ? r_dx : rx;
                    mul_b = MB_W'({1'b0, r_step});
                    use_c = U_MX;
                end
                4'd8: begin
                    mul_a = (r_op == OP_FWD || r_op == OP_BACK) ? r_sp : '0;
                    mul_b = MB_W'({1'b0, r_step});
                    use_c = U_MY;
                end
                default: begin
                    mul_a = (r_op == OP_FWD || r_op == OP_BACK) ? r_dz : r_sy;
                    mul_b = MB_W'({1'b0, r_step});
                    use_c = U_MZ;
                end
            endcase
        end else if (r_state == S_DOT) begin
            case ({r_row, r_term[2:1]})
                4'b00_00: dcomp = rx;
                4'b00_01: dcomp = '0;
                4'b00_10: dcomp = r_sy;
                4'b01_00: dcomp = r_ux;
                4'b01_01: dcomp = r_uy;
                4'b01_10: dcomp = r_uz;
                4'b10_00: dcomp = r_dx;
                4'b10_01: dcomp = r_sp;
                4'b10_10: dcomp = r_dz;
                default:  dcomp = '0;
            endcase
            mul_a = dcomp;
            if (r_term[0]) begin
                use_c = U_DLO;
                case (r_term[2:1])
                    2'd0:    mul_b = MB_W'({1'b0, r_pos_x[15:0]});
                    2'd1:    mul_b = MB_W'({1'b0, r_pos_y[15:0]});
                    default: mul_b = MB_W'({1'b0, r_pos_z[15:0]});
                endcase
            end else begin
                use_c = U_DHI;
                case (r_term[2:1])
                    2'd0:    mul_b = MB_W'(signed'(r_pos_x[POS_BITS-1:16]));
                    2'd1:    mul_b = MB_W'(signed'(r_pos_y[POS_BITS-1:16]));
                    default: mul_b = MB_W'(signed'(r_pos_z[POS_BITS-1:16]));
                endcase
            end
        end
        prod = mul_a * mul_b;
    end

    // consume path
    always_comb begin
        mtmp = r_prod + MP_W'(8388608);
        dw   = EW'(mtmp >>> 24);
        sgd  = msign ? dw : -dw;
        nx   = EW'(r_pos_x) + sgd;
        nz   = EW'(r_pos_z) + sgd;
        hi   = EW'(r_maxh) - EW'({1'b0, r_hoff});
        lo   = EW'(r_lowb) + EW'({1'b0, r_hoff});
        ny   = EW'(r_pos_y) + sgd;
        if (ny > hi) begin
            ny = hi;
        end else if (ny < lo) begin
            ny = lo;
        end
        ctb     = (r_use == U_DLO) ? ACC_W'(r_prod >>> 16) : ACC_W'(r_prod);
        acc_sum = ((r_use_term == 3'd0) ? ACC_W'(0) : r_acc) + ctb;
    end

    assign load_out = (r_state == S_OUT) && (!r_ovalid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_speed  <= 16'd2560;
            r_plim   <= 14'd12867;
            r_maxh   <= 32'sd6553600;
            r_lowb   <= '0;
            r_hoff   <= 31'd131072;
            r_pos_x  <= '0;
            r_pos_y  <= '0;
            r_pos_z  <= '0;
            r_cstart <= 1'b0;
            r_csel   <= 1'b0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_cstart <= 1'b0;

            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    CFG_MOVE_SPEED:    r_speed <= i_cfg.data[15:0];
                    CFG_PITCH_LIMIT:   r_plim  <= i_cfg.data[13:0];
                    CFG_MAX_HEIGHT:    r_maxh  <= i_cfg.data;
                    CFG_LOWER_BOUND:   r_lowb  <= i_cfg.data;
                    CFG_HEIGHT_OFFSET: r_hoff  <= i_cfg.data[30:0];
                    CFG_START_X:       r_pos_x <= sat_pos(EW'(signed'(i_cfg.data)));
                    CFG_START_Y:       r_pos_y <= sat_pos(EW'(signed'(i_cfg.data)));
                    CFG_START_Z:       r_pos_z <= sat_pos(EW'(signed'(i_cfg.data)));
                    default: ;
                endcase
            end

            // pipelined multiplier: issue now, consume next cycle
            r_pend     <= (r_state == S_MUL) || (r_state == S_DOT);
            r_prod     <= prod;
            r_use      <= use_c;
            r_use_row  <= r_row;
            r_use_term <= r_term;

            if (r_pend) begin
                case (r_use)
                    U_STEP: r_step <= r_prod[31:0];
                    U_DX:   r_dx   <= rnd16(r_prod);
                    U_DZ:   r_dz   <= rnd16(r_prod);
                    U_UX:   r_ux   <= rnd16(-r_prod);
                    U_UYA:  r_tmp  <= r_prod;
                    U_UYB:  r_uy   <= rnd16(r_tmp - r_prod);
                    U_UZ:   r_uz   <= rnd16(r_prod);
                    U_MX:   if (moving) r_pos_x <= sat_pos(nx);
                    U_MY:   if (moving) r_pos_y <= sat_pos(ny);
                    U_MZ:   if (moving) r_pos_z <= sat_pos(nz);
                    default: begin
                        r_acc <= acc_sum;
                        if (r_use_term == 3'd5) begin
                            case (r_use_row)
                                2'd0:    r_w0 <= sat_w(-acc_sum);
                                2'd1:    r_w1 <= sat_w(-acc_sum);
                                default: r_w2 <= sat_w(acc_sum);
                            endcase
                        end
                    end
                endcase
            end

            if (load_out) begin
                r_ovalid <= 1'b1;
                r_oidx   <= r_orow;
                r_olast  <= (r_orow == 2'd3);
                r_opitch <= r_pitch[14:0];
                case (r_orow)
                    2'd0: begin
                        r_ex <= 32'(rx); r_ey <= '0; r_ez <= 32'(r_sy); r_ew <= r_w0;
                    end
                    2'd1: begin
                        r_ex <= 32'(r_ux); r_ey <= 32'(r_uy); r_ez <= 32'(r_uz);
                        r_ew <= r_w1;
                    end
                    2'd2: begin
                        r_ex <= -32'(r_dx); r_ey <= -32'(r_sp); r_ez <= -32'(r_dz);
                        r_ew <= r_w2;
                    end
                    default: begin
                        r_ex <= '0; r_ey <= '0; r_ez <= '0; r_ew <= 32'sd65536;
                    end
                endcase
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_op     <= i_in.opcode;
                        r_yaw    <= PW'(i_in.yaw);
                        r_pitch  <= pitch_cl;
                        r_ts     <= i_in.time_step;
                        r_csel   <= 1'b0;
                        r_cstart <= 1'b1;
                        r_state  <= S_TRIG_Y;
                    end
                end
                S_TRIG_Y: begin
                    if (cdone) begin
                        r_sy     <= csin;
                        r_cy     <= ccos;
                        r_csel   <= 1'b1;
                        r_cstart <= 1'b1;
                        r_state  <= S_TRIG_P;
                    end
                end
                S_TRIG_P: begin
                    if (cdone) begin
                        r_sp    <= csin;
                        r_cp    <= ccos;
                        r_k     <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_k <= r_k + 4'd1;
                    if (r_k == 4'd9) begin
                        r_row   <= '0;
                        r_term  <= '0;
                        r_state <= S_DOT;
                    end
                end
                S_DOT: begin
                    if (r_term == 3'd5) begin
                        r_term <= '0;
                        r_row  <= r_row + 2'd1;
                        if (r_row == 2'd2) begin
                            r_state <= S_DRAIN;
                        end
                    end else begin
                        r_term <= r_term + 3'd1;
                    end
                end
                S_DRAIN: begin
                    r_orow  <= '0;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (load_out) begin
                        r_orow <= r_orow + 2'd1;
                        if (r_orow == 2'd3) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> dv/first_person_view_update_tb.sv
// ----------------------------------------------------------------------------
// first_person_view_update_tb
// Drives camera update transactions and register writes into the view update
// block and checks every matrix row against a bit-accurate camera predictor.
// ----------------------------------------------------------------------------
import fpv_pkg::*;

typedef struct packed {
    logic [1:0]         row_index;
    logic signed [31:0] elem_x;
    logic signed [31:0] elem_y;
    logic signed [31:0] elem_z;
    logic signed [31:0] elem_w;
    logic signed [14:0] pitch_out;
    logic               last_row;
} view_row_t;

class view_row_board;
    view_row_t rows_due[$];
    int        errors;

    function void note_input(view_row_t r[4]);
        for (int k = 0; k < 4; k++) rows_due.push_back(r[k]);
    endfunction

    function void check_row(view_row_t got);
        view_row_t want;
        if (rows_due.size() == 0) begin
            $error("unexpected row %0d", got.row_index);
            errors++;
            return;
        end
        want = rows_due.pop_front();
        if (got.row_index !== want.row_index) begin
            $error("row_index exp %0d got %0d", want.row_index, got.row_index);
            errors++;
        end
        if (got.elem_x !== want.elem_x) begin
            $error("elem_x exp %0d got %0d", want.elem_x, got.elem_x);
            errors++;
        end
        if (got.elem_y !== want.elem_y) begin
            $error("elem_y exp %0d got %0d", want.elem_y, got.elem_y);
            errors++;
        end
        if (got.elem_z !== want.elem_z) begin
            $error("elem_z exp %0d got %0d", want.elem_z, got.elem_z);
            errors++;
        end
        if (got.elem_w !== want.elem_w) begin
            $error("elem_w exp %0d got %0d", want.elem_w, got.elem_w);
            errors++;
        end
        if (got.pitch_out !== want.pitch_out) begin
            $error("pitch_out exp %0d got %0d", want.pitch_out, got.pitch_out);
            errors++;
        end
        if (got.last_row !== want.last_row) begin
            $error("last_row exp %0d got %0d", want.last_row, got.last_row);
            errors++;
        end
    endfunction
endclass

module first_person_view_update_tb;

    localparam longint Q30_PI      = 64'sd3373259426;
    localparam longint Q30_HALF_PI = 64'sd1686629713;
    localparam longint Q30_TWO_PI  = 64'sd6746518852;
    localparam longint Q30_GAIN    = 64'sd652032874;
    localparam int     WATCHDOG    = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    fpv_in_if  #(.ANGLE_BITS(16)) in_ch ();
    fpv_out_if res_ch ();
    fpv_cfg_if cfg_ch ();

    first_person_view_update i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_res  (res_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    always #5 i_clk = ~i_clk;

    view_row_board board = new();

    longint speed, plimit, hmax, hlow, hoff;
    longint cam_x, cam_y, cam_z;
    int     idle_cycles;
    int     stall_hold;
    bit     stall_on;

    localparam longint ATAN_TBL[14] = '{843314857, 497837829, 263043837, 133525159,
        67021687, 33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288,
        262144, 131072};

    function automatic longint shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_shr(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, int bits);
        longint hi, lo;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic void trig(longint ang, output longint sn, output longint cs);
        longint th, x, y, t, xs, ys;
        bit flip;
        th = ang * 131072;
        x = Q30_GAIN;
        y = 0;
        flip = 0;
        if (th > Q30_PI) th -= Q30_TWO_PI;
        else if (th < -Q30_PI) th += Q30_TWO_PI;
        if (th > Q30_HALF_PI) begin
            th -= Q30_PI;
            flip = 1;
        end else if (th < -Q30_HALF_PI) begin
            th += Q30_PI;
            flip = 1;
        end
        for (int i = 0; i < 14; i++) begin
            xs = shr(x, i);
            ys = shr(y, i);
            if (th >= 0) begin
                t = x - ys; y += xs; th -= ATAN_TBL[i];
            end else begin
                t = x + ys; y -= xs; th += ATAN_TBL[i];
            end
            x = t;
        end
        if (flip) begin
            x = -x; y = -y;
        end
        cs = round_shr(x, 14);
        sn = round_shr(y, 14);
    endfunction

    function automatic longint scale_pos(longint c, longint p);
        longint ph, pl;
        ph = shr(p, 16);
        pl = p - ph * 65536;
        return c * ph + shr(c * pl, 16);
    endfunction

    function automatic longint view_dot(longint a, longint b, longint c);
        return scale_pos(a, cam_x) + scale_pos(b, cam_y) + scale_pos(c, cam_z);
    endfunction

    function automatic view_row_t make_row(int k, longint a, longint b, longint c,
                                           longint w, longint p);
        view_row_t r;
        r.row_index = k[1:0];
        r.elem_x = 32'(clip(a, 32));
        r.elem_y = 32'(clip(b, 32));
        r.elem_z = 32'(clip(c, 32));
        r.elem_w = 32'(clip(w, 32));
        r.pitch_out = p[14:0];
        r.last_row = (k == 3);
        return r;
    endfunction

    function automatic void predict_view(logic [2:0] op, logic signed [15:0] yaw_in,
                                         logic signed [15:0] pitch_in, logic [15:0] ts,
                                         output view_row_t rows[4]);
        longint p, sy, cy, sp, cp, dx, dy, dz, rx, rz, ux, uy, uz;
        longint stp, vx, vy, vz, sg, hi, lo, y;
        p = pitch_in;
        if (p > plimit) p = plimit;
        else if (p < -plimit) p = -plimit;
        trig(yaw_in, sy, cy);
        trig(p, sp, cp);
        dx = round_shr(cp * sy, 16);
        dy = sp;
        dz = round_shr(cp * cy, 16);
        rx = -cy;
        rz = sy;
        ux = round_shr(-rz * dy, 16);
        uy = round_shr(rz * dx - rx * dz, 16);
        uz = round_shr(rx * dy, 16);
        if (op inside {OP_FWD, OP_BACK, OP_RIGHT, OP_LEFT}) begin
            stp = longint'(ts) * speed;
            vx = (op <= OP_BACK) ? dx : rx;
            vy = (op <= OP_BACK) ? dy : 0;
            vz = (op <= OP_BACK) ? dz : rz;
            sg = (op == OP_FWD || op == OP_RIGHT) ? 1 : -1;
            hi = hmax - hoff;
            lo = hlow + hoff;
            cam_x = clip(cam_x + sg * round_shr(vx * stp, 24), 32);
            cam_z = clip(cam_z + sg * round_shr(vz * stp, 24), 32);
            y = cam_y + sg * round_shr(vy * stp, 24);
            if (y > hi) y = hi;
            else if (y < lo) y = lo;
            cam_y = clip(y, 32);
        end
        rows[0] = make_row(0, rx, 0, rz, -view_dot(rx, 0, rz), p);
        rows[1] = make_row(1, ux, uy, uz, -view_dot(ux, uy, uz), p);
        rows[2] = make_row(2, -dx, -dy, -dz, view_dot(dx, dy, dz), p);
        rows[3] = make_row(3, 0, 0, 0, 65536, p);
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    initial begin
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_NONE;
        in_ch.yaw = '0;
        in_ch.pitch = '0;
        in_ch.time_step = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_MOVE_SPEED;
        cfg_ch.data = '0;
        res_ch.ready = 1'b0;
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_MOVE_SPEED:    speed = val[15:0];
            CFG_PITCH_LIMIT:   plimit = val[13:0];
            CFG_MAX_HEIGHT:    hmax = longint'($signed(val));
            CFG_LOWER_BOUND:   hlow = longint'($signed(val));
            CFG_HEIGHT_OFFSET: hoff = val[30:0];
            CFG_START_X:       cam_x = longint'($signed(val));
            CFG_START_Y:       cam_y = longint'($signed(val));
            default:           cam_z = longint'($signed(val));
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_update(logic [2:0] op, logic [15:0] yw, logic [15:0] pt,
                               logic [15:0] ts);
        view_row_t rows[4];
        int g;
        g = gap_len();
        repeat (g) @(posedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.opcode <= op;
        in_ch.yaw <= yw;
        in_ch.pitch <= pt;
        in_ch.time_step <= ts;
        do @(posedge i_clk); while (!in_ch.ready);
        in_ch.valid <= 1'b0;
        predict_view(op, yw, pt, ts, rows);
        board.note_input(rows);
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (board.rows_due.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic random_update();
        logic [15:0] yw, pt;
        int r;
        r = $urandom_range(0, 9);
        yw = 16'($urandom);
        pt = (r < 3) ? 16'($urandom_range(0, 32767)) : 16'($urandom);
        send_update(3'($urandom_range(0, 7)), yw, pt, 16'($urandom));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            stall_hold <= 0;
        end else begin
            if (stall_hold > 0) begin
                res_ch.ready <= 1'b0;
                stall_hold <= stall_hold - 1;
            end else if (stall_on) begin
                res_ch.ready <= ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 39) == 0) stall_hold <= $urandom_range(4, 40);
            end else begin
                res_ch.ready <= 1'b1;
            end
            if (res_ch.valid && res_ch.ready)
                board.check_row('{res_ch.row_index, res_ch.elem_x, res_ch.elem_y,
                    res_ch.elem_z, res_ch.elem_w, res_ch.pitch_out, res_ch.last_row});
        end
    end

    always @(posedge i_clk) begin
        if ((res_ch.valid && res_ch.ready) || (in_ch.valid && in_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("first_person_view_update: mismatch");
            $finish;
        end
    end

    initial begin
        idle_cycles = 0;
        stall_on = 0;
        speed = 2560; plimit = 12867; hmax = 6553600; hlow = 0; hoff = 131072;
        cam_x = 0; cam_y = 0; cam_z = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every opcode, angle and step extremes, pitch clamp
        send_update(OP_NONE, 16'h0000, 16'h0000, 16'h0000);
        send_update(OP_FWD, 16'h7FFF, 16'h7FFF, 16'hFFFF);
        send_update(OP_BACK, 16'h8000, 16'h8000, 16'hFFFF);
        send_update(OP_RIGHT, 16'd12868, 16'd12867, 16'h8000);
        send_update(OP_LEFT, -16'sd12868, -16'sd12868, 16'h0001);
        send_update(3'd5, 16'd25736, 16'd3000, 16'hFFFF);
        send_update(3'd6, 16'd6434, 16'd0, 16'hFFFF);
        send_update(3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        drain();

        // saturation and crossed height bounds
        write_reg(CFG_MOVE_SPEED, 32'hFFFF);
        write_reg(CFG_PITCH_LIMIT, 32'h3FFF);
        write_reg(CFG_MAX_HEIGHT, 32'h8000_0000);
        write_reg(CFG_LOWER_BOUND, 32'h7FFF_FFFF);
        write_reg(CFG_HEIGHT_OFFSET, 32'h7FFF_FFFF);
        write_reg(CFG_START_X, 32'h7FFF_0000);
        write_reg(CFG_START_Y, 32'h8000_0000);
        write_reg(CFG_START_Z, 32'h8001_0000);
        stall_on = 1;
        send_update(OP_FWD, 16'd0, 16'h7FFF, 16'hFFFF);
        send_update(OP_RIGHT, 16'd12867, 16'd0, 16'hFFFF);
        send_update(OP_BACK, 16'd25735, 16'h8000, 16'hFFFF);
        send_update(OP_LEFT, -16'sd12867, 16'd100, 16'hFFFF);
        drain();

        write_reg(CFG_PITCH_LIMIT, 32'h0);
        write_reg(CFG_MOVE_SPEED, 32'h0);
        write_reg(CFG_HEIGHT_OFFSET, 32'h0);
        write_reg(CFG_MAX_HEIGHT, 32'h7FFF_FFFF);
        write_reg(CFG_LOWER_BOUND, 32'h8000_0000);
        send_update(OP_FWD, 16'd1000, 16'd5000, 16'hFFFF);
        send_update(OP_NONE, 16'd2000, -16'sd5000, 16'h0);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            stall_on = ph[0];
            write_reg(CFG_MOVE_SPEED, $urandom_range(0, 65535));
            write_reg(CFG_PITCH_LIMIT, ph == 3 ? 12867 : $urandom_range(0, 16383));
            write_reg(CFG_MAX_HEIGHT, ph[1] ? 32'd6553600 : $urandom);
            write_reg(CFG_LOWER_BOUND, ph[1] ? 32'd0 : $urandom);
            write_reg(CFG_HEIGHT_OFFSET, $urandom_range(0, 262144));
            write_reg(CFG_START_X, $urandom);
            write_reg(CFG_START_Y, $urandom_range(0, 6553600));
            write_reg(CFG_START_Z, $urandom);
            for (int n = 0; n < 42; n++) random_update();
            drain();
        end

        if (board.errors == 0 && board.rows_due.size() == 0)
            $display("first_person_view_update: match");
        else
            $display("first_person_view_update: mismatch");
        $finish;
    end

endmodule

>>> files.f
sv/fpv_pkg.sv
sv/fpv_if.sv
sv/fpv_cordic.sv
sv/first_person_view_update.sv
dv/first_person_view_update_tb.sv
